@@ design/crl_pkg.sv @@
// ----------------------------------------------------------------------------
// crl_pkg: shared types and constants for the code range lookup
// Match kinds, action codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package crl_pkg;

  // Fixed field widths
  localparam int CFG_W    = 7;
  localparam int IDX_W    = 6;
  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 16;
  localparam int KIND_W   = 2;

  // Action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Match kinds
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXACT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INSIDE = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } crl_state_t;

endpackage

@@ design/crl_if.sv @@
// ----------------------------------------------------------------------------
// crl_if: request and response channels of the code range lookup
// Valid/ready channels carrying one request or one response transaction.
// ----------------------------------------------------------------------------
interface crl_req_if import crl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [IDX_W-1:0]  entry_index;
  logic [ADDR_W-1:0] entry_start;
  logic [LEN_W-1:0]  entry_length;
  logic              entry_native;
  logic [ADDR_W-1:0] query_offset;

  modport source (output valid, action, entry_index, entry_start, entry_length,
                  entry_native, query_offset, input ready);
  modport sink   (input valid, action, entry_index, entry_start, entry_length,
                  entry_native, query_offset, output ready);
endinterface

interface crl_rsp_if import crl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] match_kind;
  logic [IDX_W-1:0]  match_index;
  logic              first_found;
  logic [ADDR_W-1:0] first_start;

  modport source (output valid, match_kind, match_index, first_found, first_start,
                  input ready);
  modport sink   (input valid, match_kind, match_index, first_found, first_start,
                  output ready);
endinterface

@@ design/crl_ram.sv @@
// ----------------------------------------------------------------------------
// crl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/code_range_lookup_with_hint_core.sv @@
// ----------------------------------------------------------------------------
// code_range_lookup_with_hint_core: hinted code region table lookup
// Region table with write and lookup transactions and a first-start report.
// ----------------------------------------------------------------------------
// A write transaction fills one table slot. A lookup transaction scans the
// active entries for an exact or inside match, starting at the last hit and
// wrapping. The live entry count is the configured count clamped to
// TABLE_SLOTS, which is 64 by default. The scan reads one entry per cycle
// through the single read port of the region table. A mirror memory is
// searched at the same time for the lowest-index non-native start, so that
// search does not lengthen the transaction. The transaction ends before all
// live entries are read when both searches stop early: a lookup stops at
// its hit, and the first-start search stops at its first non-native entry.
// The request channel is not ready while a transaction is in work. A finished
// response waits in the output register and does not block the next request.
module code_range_lookup_with_hint_core
  import crl_pkg::*;
#(
  parameter int TABLE_SLOTS = 64,
  parameter int ADDR_BITS   = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic [CFG_W-1:0] cfg_write_data,
  crl_req_if.sink          request,
  crl_rsp_if.source        response
);

  localparam int SW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int RW = 1 + LEN_W + SW;
  localparam int MW = 1 + SW;

  crl_state_t state, state_next;

  logic [CFG_W-1:0] active_entries;
  logic [CFG_W-1:0] last_hit;
  logic [CFG_W-1:0] live_now;
  logic [CFG_W-1:0] n_q;
  logic [SW-1:0]    off_q;

  logic             accept;
  logic             wr_en;

  // Lookup scan registers
  logic [CFG_W-1:0] lk_cnt;
  logic [CFG_W-1:0] lk_addr;
  logic [CFG_W-1:0] lk_addr_inc;
  logic             lk_chk_valid;
  logic [CFG_W-1:0] lk_chk_idx;
  logic             lk_done;
  logic [KIND_W-1:0] kind;
  logic [CFG_W-1:0] hit;
  logic             lk_issue;
  logic             lk_fin;

  // First-start search registers
  logic [CFG_W-1:0] fs_addr;
  logic             fs_chk_valid;
  logic             fs_done;
  logic [SW-1:0]    first_start;
  logic             fs_issue;
  logic             fs_fin;

  // Memory data and probe
  logic [RW-1:0]    lk_rd;
  logic [MW-1:0]    fs_rd;
  logic [SW-1:0]    pr_start;
  logic [LEN_W-1:0] pr_len;
  logic             pr_native;
  logic [SW-1:0]    pr_diff;
  logic             pr_exact;
  logic             pr_inside;

  logic             out_load;

  // Live entry count, clamped to the table size
  assign live_now = (32'(active_entries) > TABLE_SLOTS) ? CFG_W'(TABLE_SLOTS)
                                                        : active_entries;

  assign request.ready = (state == ST_IDLE);
  assign accept        = request.valid && request.ready;
  assign wr_en         = accept && (request.action == ACT_WRITE) &&
                         (32'(request.entry_index) < TABLE_SLOTS);

  // Region table and its start/native mirror
  crl_ram #(.WIDTH(RW), .DEPTH(TABLE_SLOTS)) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(request.entry_index)),
    .wdata ({request.entry_native, request.entry_length,
             request.entry_start[SW-1:0]}),
    .raddr (AW'(lk_addr)),
    .rdata (lk_rd)
  );

  crl_ram #(.WIDTH(MW), .DEPTH(TABLE_SLOTS)) u_mirror (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(request.entry_index)),
    .wdata ({request.entry_native, request.entry_start[SW-1:0]}),
    .raddr (AW'(fs_addr)),
    .rdata (fs_rd)
  );

  // Probe the entry read in the previous cycle
  assign pr_native = lk_rd[RW-1];
  assign pr_len    = lk_rd[SW +: LEN_W];
  assign pr_start  = lk_rd[SW-1:0];
  assign pr_diff   = off_q - pr_start;
  assign pr_exact  = !pr_native && (off_q == pr_start);
  assign pr_inside = !pr_native && (off_q > pr_start) && (pr_diff < SW'(pr_len));

  // Scan control
  assign lk_addr_inc = lk_addr + CFG_W'(1);
  assign lk_issue    = (state == ST_SCAN) && !lk_done && (lk_cnt < n_q);
  assign lk_fin      = lk_done || ((lk_cnt >= n_q) && !lk_chk_valid);
  assign fs_issue    = (state == ST_SCAN) && !fs_done && (fs_addr < n_q);
  assign fs_fin      = fs_done || ((fs_addr >= n_q) && !fs_chk_valid);

  // Next state
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (lk_fin && fs_fin) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!response.valid || response.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= '0;
    end else if (cfg_write_en) begin
      active_entries <= cfg_write_data;
    end
  end

  // Hint register: save the index of a hit
  always_ff @(posedge clk) begin
    if (rst) begin
      last_hit <= '0;
    end else if ((state == ST_SCAN) && lk_chk_valid && !lk_done &&
                 (pr_exact || pr_inside)) begin
      last_hit <= lk_chk_idx;
    end
  end

  // Lookup scan: issue one read a cycle, check the previous read
  always_ff @(posedge clk) begin
    if (rst) begin
      lk_done      <= 1'b0;
      lk_chk_valid <= 1'b0;
      lk_cnt       <= '0;
    end else if (accept) begin
      n_q          <= live_now;
      off_q        <= request.query_offset[SW-1:0];
      lk_cnt       <= '0;
      lk_addr      <= (last_hit < live_now) ? last_hit : '0;
      lk_chk_valid <= 1'b0;
      lk_done      <= (request.action == ACT_WRITE);
      kind         <= KIND_NONE;
      hit          <= '0;
    end else if (state == ST_SCAN) begin
      lk_chk_valid <= lk_issue;
      lk_chk_idx   <= lk_addr;
      if (lk_issue) begin
        lk_cnt  <= lk_cnt + CFG_W'(1);
        lk_addr <= (lk_addr_inc >= n_q) ? '0 : lk_addr_inc;
      end
      if (lk_chk_valid && !lk_done) begin
        if (pr_exact) begin
          kind    <= KIND_EXACT;
          hit     <= lk_chk_idx;
          lk_done <= 1'b1;
        end else if (pr_inside) begin
          kind    <= KIND_INSIDE;
          hit     <= lk_chk_idx;
          lk_done <= 1'b1;
        end
      end
    end
  end

  // First-start search from index zero
  always_ff @(posedge clk) begin
    if (rst) begin
      fs_done      <= 1'b0;
      fs_chk_valid <= 1'b0;
      fs_addr      <= '0;
    end else if (accept) begin
      fs_addr      <= '0;
      fs_chk_valid <= 1'b0;
      fs_done      <= 1'b0;
      first_start  <= '0;
    end else if (state == ST_SCAN) begin
      fs_chk_valid <= fs_issue;
      if (fs_issue) begin
        fs_addr <= fs_addr + CFG_W'(1);
      end
      if (fs_chk_valid && !fs_done && !fs_rd[MW-1]) begin
        fs_done     <= 1'b1;
        first_start <= fs_rd[SW-1:0];
      end
    end
  end

  // Output register: load when free, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      response.valid <= 1'b0;
    end else if (out_load) begin
      response.valid <= 1'b1;
    end else if (response.ready) begin
      response.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      response.match_kind  <= kind;
      response.match_index <= hit[IDX_W-1:0];
      response.first_found <= fs_done;
      response.first_start <= ADDR_W'(first_start);
    end
  end

endmodule

@@ tb/sv/tb_code_range_lookup_with_hint_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_code_range_lookup_with_hint_core: self-checking bench for the region table
// Drives write and lookup transactions through the request channel and
// predicts every response from a local copy of the table, the hint and the
// active count. The bench walks through several table sizes, including empty,
// one entry, full and an oversized count. It also applies random idling on
// both channels, one long response stall and one run with no idling at all.
// ----------------------------------------------------------------------------
module tb_code_range_lookup_with_hint_core;
  import crl_pkg::*;

  localparam int TABLE_SLOTS    = 64;
  localparam int PHASE_ITEMS    = 100;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 150;
  localparam int ACTIVE_SIZES [10] = '{127, 64, 1, 2, 3, 16, 40, 63, 64, 5};

  typedef struct {
    logic              action;
    logic [IDX_W-1:0]  slot;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  length;
    logic              native;
    logic [ADDR_W-1:0] offset;
  } region_req_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  index;
    logic              found;
    logic [ADDR_W-1:0] first;
  } region_rsp_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_write_en;
  logic [CFG_W-1:0] cfg_write_data;

  crl_req_if req_ch();
  crl_rsp_if rsp_ch();

  code_range_lookup_with_hint_core #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .ADDR_BITS  (ADDR_W)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .request       (req_ch),
    .response      (rsp_ch)
  );

  // Transactions waiting to be offered, the one on the bus, results in flight
  region_req_t queued_requests [$];
  region_req_t on_bus;
  region_rsp_t awaited_results [$];
  region_rsp_t oldest_result;

  // Predicted table state, updated at acceptance
  logic [ADDR_W-1:0] tbl_start  [TABLE_SLOTS];
  logic [LEN_W-1:0]  tbl_length [TABLE_SLOTS];
  logic              tbl_native [TABLE_SLOTS];
  logic [IDX_W-1:0]  tbl_hint;
  int                tbl_active;

  // Table contents as planned by the stimulus, used to aim lookups
  logic [ADDR_W-1:0] plan_start  [TABLE_SLOTS];
  logic [LEN_W-1:0]  plan_length [TABLE_SLOTS];
  int                plan_active;

  int   tx_idle_pct;
  int   rx_idle_pct;
  logic rx_hold_armed;
  int   rx_hold_left;
  int   error_count;
  int   write_count;
  int   lookup_count;
  int   exact_count;
  int   inside_count;
  int   size_count;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one transaction to the predicted table and return its result
  function automatic region_rsp_t predict_region_result(region_req_t r);
    region_rsp_t res;
    int          live;
    int          pos;
    int          k;
    logic        hit;
    res.kind  = KIND_NONE;
    res.index = '0;
    res.found = 1'b0;
    res.first = '0;
    hit       = 1'b0;
    live      = (tbl_active > TABLE_SLOTS) ? TABLE_SLOTS : tbl_active;
    if (r.action == ACT_WRITE) begin
      tbl_start[r.slot]  = r.start;
      tbl_length[r.slot] = r.length;
      tbl_native[r.slot] = r.native;
    end else if (live > 0) begin
      // start at the hint, or at zero when the hint is past the live count
      pos = (tbl_hint < live) ? int'(tbl_hint) : 0;
      for (k = 0; k < live && !hit; k++) begin
        if (!tbl_native[pos]) begin
          if (r.offset == tbl_start[pos]) begin
            res.kind = KIND_EXACT;
            hit      = 1'b1;
          end else if (r.offset > tbl_start[pos] &&
                       (r.offset - tbl_start[pos]) < tbl_length[pos]) begin
            res.kind = KIND_INSIDE;
            hit      = 1'b1;
          end
        end
        if (hit) begin
          res.index = pos[IDX_W-1:0];
          tbl_hint  = pos[IDX_W-1:0];
        end else begin
          pos = (pos + 1 >= live) ? 0 : pos + 1;
        end
      end
    end
    // lowest-index non-native entry
    for (k = 0; k < live && !res.found; k++) begin
      if (!tbl_native[k]) begin
        res.found = 1'b1;
        res.first = tbl_start[k];
      end
    end
    return res;
  endfunction

  function automatic int plan_live();
    return (plan_active > TABLE_SLOTS) ? TABLE_SLOTS : plan_active;
  endfunction

  function automatic void push_write(logic [IDX_W-1:0] slot, logic [ADDR_W-1:0] start,
                                     logic [LEN_W-1:0] length, logic native);
    region_req_t r;
    r.action = ACT_WRITE;
    r.slot   = slot;
    r.start  = start;
    r.length = length;
    r.native = native;
    r.offset = $urandom;
    plan_start[slot]  = start;
    plan_length[slot] = length;
    queued_requests.push_back(r);
  endfunction

  function automatic void push_lookup(logic [ADDR_W-1:0] offset);
    region_req_t r;
    r.action = ACT_LOOKUP;
    r.slot   = IDX_W'($urandom);
    r.start  = $urandom;
    r.length = LEN_W'($urandom);
    r.native = 1'($urandom);
    r.offset = offset;
    queued_requests.push_back(r);
  endfunction

  // Write with starts that often overlap or sit near the top of the space
  function automatic void push_random_write();
    int                live;
    int                pick;
    int                src;
    int                slot;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  length;
    live = plan_live();
    src  = $urandom_range(TABLE_SLOTS - 1);
    pick = $urandom_range(99);
    if (pick < 40) start = $urandom;
    else if (pick < 65) start = plan_start[src] + $urandom_range(64) - 32;
    else if (pick < 80) start = plan_start[src];
    else start = {16'hFFFF, 16'($urandom)};
    pick = $urandom_range(99);
    if (pick < 10) length = '0;
    else if (pick < 20) length = '1;
    else length = LEN_W'($urandom_range(4096, 1));
    if (live > 0 && $urandom_range(99) < 70) slot = $urandom_range(live - 1);
    else slot = $urandom_range(TABLE_SLOTS - 1);
    push_write(IDX_W'(slot), start, length, $urandom_range(99) < 20);
  endfunction

  // Lookup mostly aimed at a live entry: its start, inside it, just past it or below; else a random offset
  function automatic void push_random_lookup();
    int                live;
    int                pick;
    int                slot;
    logic [ADDR_W-1:0] offset;
    live = plan_live();
    slot = (live > 0) ? $urandom_range(live - 1) : 0;
    pick = $urandom_range(99);
    if (live == 0 || pick < 20) offset = $urandom;
    else if (pick < 55) offset = plan_start[slot];
    else if (pick < 85) offset = plan_start[slot] + ((plan_length[slot] > 1) ?
                                 $urandom_range(plan_length[slot] - 1, 1) : 1);
    else if (pick < 95) offset = plan_start[slot] + plan_length[slot];
    else offset = plan_start[slot] - 1;
    push_lookup(offset);
  endfunction

  // Hold until nothing is queued, offered or outstanding
  task automatic wait_for_idle();
    do @(negedge clk);
    while (queued_requests.size() != 0 || req_ch.valid || awaited_results.size() != 0);
  endtask

  task automatic set_active_entries(int count);
    wait_for_idle();
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= CFG_W'(count);
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    plan_active = count;
    size_count++;
    @(negedge clk);
  endtask

  // Request driver: predict on acceptance, then offer the next transaction
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (cfg_write_en) tbl_active = int'(cfg_write_data);
      if (req_ch.valid && req_ch.ready) begin
        awaited_results.push_back(predict_region_result(on_bus));
        if (on_bus.action == ACT_WRITE) write_count++;
        else lookup_count++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (queued_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          on_bus = queued_requests.pop_front();
          req_ch.valid        <= 1'b1;
          req_ch.action       <= on_bus.action;
          req_ch.entry_index  <= on_bus.slot;
          req_ch.entry_start  <= on_bus.start;
          req_ch.entry_length <= on_bus.length;
          req_ch.entry_native <= on_bus.native;
          req_ch.query_offset <= on_bus.offset;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [ADDR_W-1:0] want,
                                      logic [ADDR_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Response monitor: compare against the oldest prediction, pace ready
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d index %0d",
                   $time, rsp_ch.match_kind, rsp_ch.match_index);
          error_count++;
        end else begin
          oldest_result = awaited_results.pop_front();
          check_field("match_kind", ADDR_W'(oldest_result.kind),
                      ADDR_W'(rsp_ch.match_kind));
          check_field("match_index", ADDR_W'(oldest_result.index),
                      ADDR_W'(rsp_ch.match_index));
          check_field("first_found", ADDR_W'(oldest_result.found),
                      ADDR_W'(rsp_ch.first_found));
          check_field("first_start", oldest_result.first, rsp_ch.first_start);
          if (oldest_result.kind == KIND_EXACT) exact_count++;
          if (oldest_result.kind == KIND_INSIDE) inside_count++;
        end
      end
      if (rx_hold_armed) begin
        rx_hold_left  = RX_HOLD_CYCLES;
        rx_hold_armed = 1'b0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Stimulus
  initial begin
    int ph;
    int i;
    rst                 = 1'b1;
    cfg_write_en        = 1'b0;
    cfg_write_data      = '0;
    req_ch.valid        = 1'b0;
    req_ch.action       = ACT_WRITE;
    req_ch.entry_index  = '0;
    req_ch.entry_start  = '0;
    req_ch.entry_length = '0;
    req_ch.entry_native = 1'b0;
    req_ch.query_offset = '0;
    rsp_ch.ready        = 1'b0;
    tbl_hint            = '0;
    tbl_active          = 0;
    plan_active         = 0;
    tx_idle_pct         = 25;
    rx_idle_pct         = 25;
    rx_hold_armed       = 1'b0;
    rx_hold_left        = 0;
    error_count         = 0;
    write_count         = 0;
    lookup_count        = 0;
    exact_count         = 0;
    inside_count        = 0;
    size_count          = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty table, then load every slot so no live entry is ever unwritten
    set_active_entries(0);
    push_lookup('0);
    push_lookup('1);
    for (i = 0; i < TABLE_SLOTS; i++) begin
      push_write(IDX_W'(i), $urandom, LEN_W'($urandom), $urandom_range(99) < 20);
    end

    // Native skip, exact and inside hits, end boundary, top of space, wrap
    set_active_entries(4);
    push_write(IDX_W'(0), 32'h0000_1000, 16'h0100, 1'b1);
    push_write(IDX_W'(1), 32'h0000_1000, 16'h0010, 1'b0);
    push_write(IDX_W'(2), 32'hFFFF_FF00, 16'hFFFF, 1'b0);
    push_write(IDX_W'(3), 32'h0000_0000, 16'h0000, 1'b0);
    push_lookup(32'h0000_1000);
    push_lookup(32'h0000_1008);
    push_lookup(32'h0000_1010);
    push_lookup(32'h0000_1050);
    push_lookup(32'hFFFF_FFFF);
    push_lookup(32'h0000_0000);
    push_lookup(32'h0000_0001);
    push_write(IDX_W'(0), 32'h0000_1000, 16'h0100, 1'b0);
    push_lookup(32'h0000_1004);
    push_lookup(32'h0000_0000);

    // Hint left past a smaller count, then an all-native table
    set_active_entries(2);
    push_lookup(32'h0000_1000);
    push_write(IDX_W'(0), 32'h0000_1000, 16'h0100, 1'b1);
    push_write(IDX_W'(1), 32'h0000_2000, 16'hFFFF, 1'b1);
    push_lookup(32'h0000_1000);
    push_lookup(32'h0000_0000);

    // Random phases over several table sizes
    for (ph = 0; ph < $size(ACTIVE_SIZES); ph++) begin
      set_active_entries(ACTIVE_SIZES[ph]);
      tx_idle_pct = (ph == 1) ? 0 : 25;
      rx_idle_pct = (ph == 1) ? 0 : 25;
      if (ph == 5) rx_hold_armed = 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 25) push_random_write();
        else push_random_lookup();
      end
    end

    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d writes and %0d lookups over %0d table sizes.",
             write_count, lookup_count, size_count);
    $display("Lookups gave %0d exact hits and %0d inside hits.", exact_count, inside_count);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
